>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file crp_checker.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/crp_pkg.sv
// ----------------------------------------------------------------------------
// crp_pkg
// types, codes and pacing arithmetic for the chunk retransmit pacer
// ----------------------------------------------------------------------------
package crp_pkg;

	// request codes
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_SLOT  = 2'd1;
	localparam logic [1:0] REQ_RETRY = 2'd2;

	typedef enum logic [2:0] {
		ST_SENT      = 3'd0,
		ST_IDLE      = 3'd1,
		ST_STARTED   = 3'd2,
		ST_RETRY_OK  = 3'd3,
		ST_RETRY_IGN = 3'd4
	} status_t;

	localparam logic [7:0]  PACE_RESET  = 8'd15;
	localparam logic [7:0]  PACE_CEIL   = 8'd200;
	localparam logic [7:0]  PACE_FLOOR  = 8'd25;
	localparam logic [6:0]  CLEAN_LIMIT = 7'd100;
	localparam logic [3:0]  FINAL_LIMIT = 4'd10;
	localparam logic [16:0] MAX_CHUNKS  = 17'd65536;

	// image length plus a chunk minus one always fits here
	localparam int IMG_W = 24;
	localparam int DIV_W = 25;

	// w*11/10 as w*(11*ceil(2^19/10)) >> 19, exact for w*11 below 2^18
	localparam logic [19:0] PACE_UP_MUL = 20'd576719;
	// w*10/11 as w*(10*ceil(2^20/11)) >> 20, exact for w*10 below 2^16
	localparam logic [19:0] PACE_DN_MUL = 20'd953260;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] restart_chunk;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] chunk_index;
		logic [23:0] byte_offset;
		logic [8:0]  byte_count;
		logic [7:0]  pace_ms;
		logic        slow_pause;
		logic        final_pause;
		logic [16:0] chunk_total;
	} result_t;

	// only used with w below the ceiling, so the result stays in 8 bits
	function automatic logic [7:0] pace_up(input logic [7:0] w);
		logic [27:0] p;
		p = 28'(w) * 28'(PACE_UP_MUL);
		return p[26:19];
	endfunction

	function automatic logic [7:0] pace_down(input logic [7:0] w);
		logic [27:0] p;
		p = 28'(w) * 28'(PACE_DN_MUL);
		return p[27:20];
	endfunction

endpackage

>>> design/crp_in_reg.sv
// ----------------------------------------------------------------------------
// crp_in_reg
// input register stage: unless stalled, captures one request beat per cycle
// ----------------------------------------------------------------------------
module crp_in_reg (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [1:0]     req_type,
	input  logic [15:0]    restart_chunk,
	input  logic           advance,
	output logic           in_stall,
	output logic           valid_s1,
	output crp_pkg::item_t item_s1
);
	import crp_pkg::*;

	logic load;

	// stage is free when empty or when its beat moves on this cycle
	assign in_stall = valid_s1 & ~advance;
	assign load     = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.req_type      <= req_type;
			item_s1.restart_chunk <= restart_chunk;
		end
	end

endmodule

>>> design/crp_core.sv
// ----------------------------------------------------------------------------
// crp_core
// transfer state and the per-request logic that forms one result
// ----------------------------------------------------------------------------
module crp_core #(
	parameter int CHUNK_BYTES = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [23:0]      cfg_wr_data,
	input  logic             advance,
	input  crp_pkg::item_t   item_s1,
	output crp_pkg::result_t res
);
	import crp_pkg::*;

	localparam int CB_W   = $clog2(CHUNK_BYTES + 1);
	localparam int OFF_W  = 16 + CB_W;
	localparam int CMP_W  = (OFF_W > IMG_W) ? OFF_W : IMG_W;
	// reciprocal for the chunk count: exact floor for any dividend below 2^DIV_W
	localparam int SHIFT  = DIV_W + $clog2(CHUNK_BYTES);
	localparam int RCP_W  = DIV_W + 2;
	localparam int PROD_W = DIV_W + RCP_W;
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES);

	logic [23:0] image_q;
	logic [15:0] next_q,  next_d;
	logic [16:0] total_q, total_d;
	logic [7:0]  pace_q,  pace_d;
	logic        retry_q, retry_d;
	logic [6:0]  clean_q, clean_d, clean_mid;
	logic [3:0]  final_q, final_d;
	logic        run_q,   run_d;

	logic [DIV_W-1:0]  dividend;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] quot_w;
	logic [DIV_W-1:0]  quot;
	logic [16:0]       cnt;
	logic [OFF_W-1:0]  off;
	logic [CMP_W-1:0]  off_x, img_x, rem_x, cnt_x;
	logic              last;

	// chunk count as ceil(image/CHUNK_BYTES), saturated
	assign dividend = DIV_W'(image_q) + DIV_W'(CHUNK_BYTES - 1);
	assign prod     = PROD_W'(dividend) * PROD_W'(RCP_W'(RECIP));
	assign quot_w   = prod >> SHIFT;
	assign quot     = quot_w[DIV_W-1:0];
	assign cnt      = (quot > DIV_W'(MAX_CHUNKS)) ? MAX_CHUNKS : quot[16:0];

	// byte offset and tail length of the current chunk
	assign off   = OFF_W'(next_q) * OFF_W'(CHUNK_BYTES);
	assign off_x = CMP_W'(off);
	assign img_x = CMP_W'(image_q);
	assign rem_x = img_x - off_x;
	assign cnt_x = (img_x <= off_x) ? '0 :
		(rem_x > CMP_W'(CHUNK_BYTES)) ? CMP_W'(CHUNK_BYTES) : rem_x;
	assign last  = ({1'b0, next_q} == (total_q - 17'd1));

	always_comb begin
		next_d    = next_q;
		total_d   = total_q;
		pace_d    = pace_q;
		retry_d   = retry_q;
		clean_d   = clean_q;
		clean_mid = clean_q;
		final_d   = final_q;
		run_d     = run_q;
		res        = '0;
		res.status = ST_IDLE;
		unique case (item_s1.req_type)
			REQ_START: begin
				total_d         = cnt;
				next_d          = '0;
				pace_d          = PACE_RESET;
				final_d         = '0;
				run_d           = (cnt != '0);
				res.status      = ST_STARTED;
				res.pace_ms     = PACE_RESET;
				res.chunk_total = cnt;
			end
			REQ_SLOT: begin
				if (run_q && ({1'b0, next_q} < total_q) && (final_q < FINAL_LIMIT)) begin
					res.pace_ms = pace_q;
					if (retry_q && (pace_q < PACE_CEIL)) begin
						pace_d         = pace_up(pace_q);
						retry_d        = 1'b0;
						res.slow_pause = 1'b1;
					end else if ((clean_q >= CLEAN_LIMIT) && (pace_q > PACE_FLOOR)) begin
						pace_d    = pace_down(pace_q);
						clean_mid = '0;
					end
					if (last) begin
						res.byte_count  = cnt_x[8:0];
						final_d         = final_q + 4'd1;
						res.final_pause = 1'b1;
					end else begin
						res.byte_count = 9'(CHUNK_BYTES);
						final_d        = '0;
						next_d         = next_q + 16'd1;
					end
					clean_d         = (clean_mid < CLEAN_LIMIT) ? clean_mid + 7'd1 : clean_mid;
					res.status      = ST_SENT;
					res.chunk_index = next_q;
					res.byte_offset = off_x[23:0];
				end else begin
					run_d = 1'b0;
				end
			end
			REQ_RETRY: begin
				if (next_q < item_s1.restart_chunk) begin
					res.status      = ST_RETRY_IGN;
					res.chunk_index = next_q;
				end else begin
					next_d          = item_s1.restart_chunk;
					retry_d         = 1'b1;
					clean_d         = '0;
					res.status      = ST_RETRY_OK;
					res.chunk_index = item_s1.restart_chunk;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_q <= '0;
		end else if (cfg_wr_en) begin
			image_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q  <= '0;
			total_q <= '0;
			pace_q  <= PACE_RESET;
			retry_q <= 1'b0;
			clean_q <= '0;
			final_q <= '0;
			run_q   <= 1'b0;
		end else if (advance) begin
			next_q  <= next_d;
			total_q <= total_d;
			pace_q  <= pace_d;
			retry_q <= retry_d;
			clean_q <= clean_d;
			final_q <= final_d;
			run_q   <= run_d;
		end
	end

endmodule

>>> design/crp_out_reg.sv
// ----------------------------------------------------------------------------
// crp_out_reg
// result register: holds a finished beat until the consumer takes it
// ----------------------------------------------------------------------------
module crp_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  crp_pkg::result_t res,
	input  logic             out_stall,
	output logic             out_valid,
	output crp_pkg::result_t res_q
);
	import crp_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

>>> design/chunk_retransmit_pacer.sv
// ----------------------------------------------------------------------------
// chunk_retransmit_pacer
// sender side of a chunked image transfer with go-back retries and pacing
// ----------------------------------------------------------------------------
// flow: an accepted beat is held in the input register, then moves into the result register
// throughput: one request beat per cycle while out_stall is low, set by the input and result registers
// the start path's reciprocal multiply and the offset multiply sit in one stage
// reset: async active low; idle, pace 15, no pending retry, image length 0
// ----------------------------------------------------------------------------
module chunk_retransmit_pacer #(
	parameter int CHUNK_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: image length in bytes
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [15:0] restart_chunk,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] chunk_index,
	output logic [23:0] byte_offset,
	output logic [8:0]  byte_count,
	output logic [7:0]  pace_ms,
	output logic        slow_pause,
	output logic        final_pause,
	output logic [16:0] chunk_total
);
	import crp_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    advance;
	result_t res;
	result_t res_q;

	// the held beat moves into the result register when that register is
	// empty or being drained in the same cycle; state commits at that point
	assign advance = valid_s1 & (~out_valid | ~out_stall);

	// input register, stalls only when its beat cannot move on
	crp_in_reg u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.req_type      (req_type),
		.restart_chunk (restart_chunk),
		.advance       (advance),
		.in_stall      (in_stall),
		.valid_s1      (valid_s1),
		.item_s1       (item_s1)
	);

	// transfer state, chunk math and pacing adaptation
	crp_core #(
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.advance     (advance),
		.item_s1     (item_s1),
		.res         (res)
	);

	// result register decouples the consumer from the request side
	crp_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign status      = res_q.status;
	assign chunk_index = res_q.chunk_index;
	assign byte_offset = res_q.byte_offset;
	assign byte_count  = res_q.byte_count;
	assign pace_ms     = res_q.pace_ms;
	assign slow_pause  = res_q.slow_pause;
	assign final_pause = res_q.final_pause;
	assign chunk_total = res_q.chunk_total;

endmodule

>>> design/crp_checker.sv
// ----------------------------------------------------------------------------
// crp_checker
// port-level checks on the pacer's result beats
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [15:0] chunk_index,
	input logic [23:0] byte_offset,
	input logic [8:0]  byte_count,
	input logic [7:0]  pace_ms,
	input logic        slow_pause,
	input logic        final_pause,
	input logic [16:0] chunk_total
);
	import crp_pkg::*;

	// start beat carries only the chunk total and the reset pace
	`ASSERT_ALWAYS(a_start_fields, !(out_valid && status == ST_STARTED) || (chunk_index == '0 && byte_offset == '0 && byte_count == '0 && pace_ms == PACE_RESET && !slow_pause && !final_pause), "start beat has stray fields")

	// slowdown only on a sent chunk whose delay was under the ceiling
	`ASSERT_ALWAYS(a_slow_sent, !(out_valid && slow_pause) || (status == ST_SENT && pace_ms < PACE_CEIL), "slow pause outside a sent chunk")

	// final pause only on a sent chunk, and chunk total only on start
	`ASSERT_ALWAYS(a_final_sent, !(out_valid && (final_pause || chunk_total != '0)) || (final_pause ? status == ST_SENT : status == ST_STARTED), "final pause or total on wrong beat")

	// a stalled result beat stays valid and keeps its status, chunk index and pace
	`ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(chunk_index) && $stable(pace_ms), "stalled result beat changed")

endmodule

bind chunk_retransmit_pacer crp_checker u_crp_checker (.*);
